// ===== src/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/zmrx_pkg.sv =====
package zmrx_pkg;

  localparam int unsigned PosW = 32;
  localparam int unsigned CntW = 11;
  localparam int unsigned RetryW = 9;
  localparam logic [7:0] RetryLimitRst = 8'd20;

  typedef enum logic [1:0] {
    REQ_START,
    REQ_HEADER,
    REQ_SUBPKT,
    REQ_ABORT
  } req_e;

  typedef enum logic [2:0] {
    HK_NAK,
    HK_TIMEOUT,
    HK_FILE,
    HK_EOF,
    HK_GARBAGE,
    HK_SKIP,
    HK_DATA,
    HK_OTHER
  } hdr_kind_e;

  typedef enum logic [2:0] {
    SE_CANCEL,
    SE_CRC_ERR,
    SE_TIMEOUT,
    SE_CRCW,
    SE_CRCQ,
    SE_CRCG,
    SE_CRCE
  } sp_end_e;

  typedef enum logic [2:0] {
    ACT_HDR,
    ACT_ATTN,
    ACT_XON,
    ACT_WRITE,
    ACT_FINISH
  } action_e;

  typedef enum logic {
    HT_ZRPOS,
    HT_ZACK
  } hdr_type_e;

  typedef enum logic [1:0] {
    FIN_EOF,
    FIN_SKIP,
    FIN_ERROR
  } fin_e;

  typedef struct packed {
    action_e           action;
    hdr_type_e         htype;
    logic [PosW-1:0]   pos;
    logic [CntW-1:0]   wcnt;
    fin_e              fin;
  } res_t;

  function automatic res_t mk_res(action_e a, hdr_type_e h, logic [PosW-1:0] p,
                                  logic [CntW-1:0] w, fin_e f);
    res_t r;
    r.action = a;
    r.htype  = h;
    r.pos    = p;
    r.wcnt   = w;
    r.fin    = f;
    return r;
  endfunction

endpackage

// ===== src/zmrx_if.sv =====
interface zmrx_req_if;
  import zmrx_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      req_type;
  logic [2:0]      header_kind;
  logic [PosW-1:0] header_position;
  logic [2:0]      subpacket_end;
  logic [CntW-1:0] subpacket_count;

  modport source (
    output valid, req_type, header_kind, header_position, subpacket_end, subpacket_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, header_kind, header_position, subpacket_end, subpacket_count,
    output ready
  );
endinterface

interface zmrx_res_if;
  import zmrx_pkg::*;

  logic            valid;
  logic            ready;
  logic [2:0]      action;
  logic            send_header_type;
  logic [PosW-1:0] send_position;
  logic [CntW-1:0] write_count;
  logic [1:0]      finish_status;
  logic            last_of_run;

  modport source (
    output valid, action, send_header_type, send_position, write_count, finish_status,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, action, send_header_type, send_position, write_count, finish_status,
           last_of_run,
    output ready
  );
endinterface

// ===== src/zmodem_receive_data_controller.sv =====
// Channel  | Dir | Payload
// ---------+-----+-------------------------------------------------------------
// req_i    | in  | req_type, header_kind, header_position, subpacket_end, count
// res_o    | out | action, send_header_type, send_position, write_count,
//          |     | finish_status, last_of_run
// cfg      | in  | cfg_we_i / cfg_data_i: retry_limit
//
// A request is held in the input register, is decoded into the result register
// once that register is free, and its 0 to 3 results then leave one per cycle
// while res_o is ready. The input register can take the next request while the
// result register drains; the drain of the result register paces the requests.
// Reset (async, active low) clears phase, position, budget, valids; retry_limit
// returns to 20. A stalled res_o holds its result; req_i keeps one request.
module zmodem_receive_data_controller #(
  parameter int unsigned MAX_SUBPACKET = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  zmrx_req_if.sink   req_i,
  zmrx_res_if.source res_o
);
  import zmrx_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DATA,
    PH_SKIP
  } phase_e;

  logic [7:0]        retry_limit_q;

  logic              in_vld_q;
  logic [1:0]        req_type_q;
  logic [2:0]        kind_q;
  logic [PosW-1:0]   hpos_q;
  logic [2:0]        end_q;
  logic [CntW-1:0]   cnt_q;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   fpos_q, fpos_d;
  logic [RetryW-1:0] ret_q, ret_d;

  res_t              bun_q [3];
  res_t              res_d [3];
  logic [1:0]        bcnt_q, bcnt_d;
  logic [1:0]        idx_q;
  logic              bun_vld_q;

  logic              fire, out_take, out_last;
  logic [CntW-1:0]   sat_cnt;
  logic [PosW-1:0]   pos_after;
  res_t              zrpos, fail_err;
  res_t              cur;

  assign out_take = res_o.valid && res_o.ready;
  assign out_last = idx_q == (bcnt_q - 2'd1);
  assign fire     = in_vld_q && (!bun_vld_q || (out_take && out_last));
  assign req_i.ready = !in_vld_q || fire;

  assign sat_cnt   = (32'(cnt_q) > 32'(MAX_SUBPACKET)) ? CntW'(MAX_SUBPACKET) : cnt_q;
  assign pos_after = fpos_q + PosW'(sat_cnt);
  assign zrpos     = mk_res(ACT_HDR, HT_ZRPOS, fpos_q, '0, FIN_EOF);
  assign fail_err  = mk_res(ACT_FINISH, HT_ZRPOS, '0, '0, FIN_ERROR);

  always_comb begin
    phase_d  = phase_q;
    fpos_d   = fpos_q;
    ret_d    = ret_q;
    bcnt_d   = 2'd0;
    res_d[0] = '0;
    res_d[1] = '0;
    res_d[2] = '0;
    case (req_e'(req_type_q))
      REQ_START: begin
        fpos_d   = '0;
        ret_d    = RetryW'(retry_limit_q);
        phase_d  = PH_WAIT;
        res_d[0] = mk_res(ACT_HDR, HT_ZRPOS, '0, '0, FIN_EOF);
        bcnt_d   = 2'd1;
      end
      REQ_HEADER: begin
        if (phase_q == PH_WAIT) begin
          case (hdr_kind_e'(kind_q))
            HK_NAK, HK_TIMEOUT: begin
              bcnt_d = 2'd1;
              if (ret_q == '0) begin
                res_d[0] = fail_err;
                phase_d  = PH_IDLE;
              end else begin
                ret_d    = ret_q - RetryW'(1);
                res_d[0] = zrpos;
              end
            end
            HK_FILE: phase_d = PH_SKIP;
            HK_EOF: begin
              if (hpos_q == fpos_q) begin
                res_d[0] = mk_res(ACT_FINISH, HT_ZRPOS, '0, '0, FIN_EOF);
                phase_d  = PH_IDLE;
                bcnt_d   = 2'd1;
              end
            end
            HK_SKIP: begin
              res_d[0] = mk_res(ACT_FINISH, HT_ZRPOS, '0, '0, FIN_SKIP);
              phase_d  = PH_IDLE;
              bcnt_d   = 2'd1;
            end
            HK_GARBAGE, HK_DATA: begin
              if (hdr_kind_e'(kind_q) == HK_DATA && hpos_q == fpos_q) begin
                phase_d = PH_DATA;
              end else if (ret_q == '0) begin
                res_d[0] = fail_err;
                phase_d  = PH_IDLE;
                bcnt_d   = 2'd1;
              end else begin
                ret_d    = ret_q - RetryW'(1);
                res_d[0] = mk_res(ACT_ATTN, HT_ZRPOS, '0, '0, FIN_EOF);
                res_d[1] = zrpos;
                bcnt_d   = 2'd2;
              end
            end
            default: begin
              res_d[0] = fail_err;
              phase_d  = PH_IDLE;
              bcnt_d   = 2'd1;
            end
          endcase
        end
      end
      REQ_SUBPKT: begin
        if (phase_q == PH_DATA) begin
          case (sp_end_e'(end_q))
            SE_CANCEL: begin
              res_d[0] = fail_err;
              phase_d  = PH_IDLE;
              bcnt_d   = 2'd1;
            end
            SE_CRC_ERR, SE_TIMEOUT: begin
              if (ret_q == '0) begin
                res_d[0] = fail_err;
                phase_d  = PH_IDLE;
                bcnt_d   = 2'd1;
              end else begin
                ret_d   = ret_q - RetryW'(1);
                phase_d = PH_WAIT;
                if (sp_end_e'(end_q) == SE_CRC_ERR) begin
                  res_d[0] = mk_res(ACT_ATTN, HT_ZRPOS, '0, '0, FIN_EOF);
                  res_d[1] = zrpos;
                  bcnt_d   = 2'd2;
                end else begin
                  res_d[0] = zrpos;
                  bcnt_d   = 2'd1;
                end
              end
            end
            SE_CRCW, SE_CRCQ, SE_CRCG, SE_CRCE: begin
              ret_d    = RetryW'(retry_limit_q);
              fpos_d   = pos_after;
              res_d[0] = mk_res(ACT_WRITE, HT_ZRPOS, '0, sat_cnt, FIN_EOF);
              res_d[1] = mk_res(ACT_HDR, HT_ZACK, pos_after, '0, FIN_EOF);
              res_d[2] = mk_res(ACT_XON, HT_ZRPOS, '0, '0, FIN_EOF);
              bcnt_d   = 2'd1;
              if (sp_end_e'(end_q) == SE_CRCW) begin
                bcnt_d  = 2'd3;
                phase_d = PH_WAIT;
              end else if (sp_end_e'(end_q) == SE_CRCQ) begin
                bcnt_d = 2'd2;
              end else if (sp_end_e'(end_q) == SE_CRCE) begin
                phase_d = PH_WAIT;
              end
            end
            default: begin
              phase_d  = PH_WAIT;
              res_d[0] = zrpos;
              bcnt_d   = 2'd1;
            end
          endcase
        end else if (phase_q == PH_SKIP) begin
          phase_d  = PH_WAIT;
          res_d[0] = zrpos;
          bcnt_d   = 2'd1;
        end
      end
      default: begin
        if (phase_q != PH_IDLE) begin
          res_d[0] = fail_err;
          phase_d  = PH_IDLE;
          bcnt_d   = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RetryLimitRst;
    end else if (cfg_we_i) begin
      retry_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q <= req_i.req_type;
      kind_q     <= req_i.header_kind;
      hpos_q     <= req_i.header_position;
      end_q      <= req_i.subpacket_end;
      cnt_q      <= req_i.subpacket_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fpos_q  <= '0;
      ret_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      fpos_q  <= fpos_d;
      ret_q   <= ret_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_vld_q <= 1'b0;
      bcnt_q    <= 2'd0;
      idx_q     <= 2'd0;
    end else if (fire) begin
      bun_vld_q <= bcnt_d != 2'd0;
      bcnt_q    <= bcnt_d;
      idx_q     <= 2'd0;
    end else if (out_take) begin
      if (out_last) begin
        bun_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      bun_q <= res_d;
    end
  end

  assign cur = bun_q[idx_q];

  assign res_o.valid            = bun_vld_q;
  assign res_o.action           = cur.action;
  assign res_o.send_header_type = cur.htype;
  assign res_o.send_position    = cur.pos;
  assign res_o.write_count      = cur.wcnt;
  assign res_o.finish_status    = cur.fin;
  assign res_o.last_of_run      = out_last;

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_idx_in_run, bun_vld_q, (idx_q < bcnt_q), "result index beyond run length")
  `ASSERT_IMPL(a_finish_last, res_o.valid && res_o.action == ACT_FINISH,
               res_o.last_of_run, "file finish is not last of run")
  `ASSERT_NEXT(a_silent_empty, fire && bcnt_d == 2'd0, !bun_vld_q,
               "request with no results left results pending")
  `ASSERT_IMPL(a_zack_is_hdr, res_o.valid && res_o.send_header_type == HT_ZACK,
               res_o.action == ACT_HDR, "ZACK type on non-header result")

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zmrx_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PER_SET  = 42;
  localparam int NUM_DIR       = 36;
  localparam int MAX_SUBPKT    = 1024;
  localparam logic [2:0] SE_UNDEF = 3'd7;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_WAIT,
    RX_DATA,
    RX_DISCARD
  } rx_phase_e;

  typedef struct {
    req_e            kind;
    hdr_kind_e       hk;
    logic [PosW-1:0] hpos;
    logic [2:0]      spend;
    logic [CntW-1:0] cnt;
  } zm_req_t;

  typedef struct {
    action_e         action;
    hdr_type_e       htype;
    logic [PosW-1:0] pos;
    logic [CntW-1:0] wcnt;
    fin_e            fin;
    logic            last;
  } rx_out_t;

  // typed rows carry a single result: ZRPOS at 0 or a finish code
  typedef struct {
    int      set_limit;
    int      reps;
    zm_req_t rq;
    bit      typed;
    action_e act;
    fin_e    fin;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  zmrx_req_if req_if ();
  zmrx_res_if res_if ();

  zmodem_receive_data_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // receiver state as predicted
  rx_phase_e       rx_phase;
  logic [PosW-1:0] file_pos;
  logic [RetryW-1:0] retries;
  logic [7:0]      retry_lim;

  rx_out_t batch[$];
  rx_out_t results_due[$];

  bit calm;
  int mismatches;
  int requests_sent;
  int directed_sent;
  int results_seen;
  int settings_cnt;
  int cycle_cnt;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{-1,  1, '{REQ_ABORT,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_START,  HK_OTHER,   32'hFFFF_FFFF, SE_UNDEF,   11'h7FF}, 1'b1, ACT_HDR, FIN_EOF},
    '{-1, 20, '{REQ_HEADER, HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_TIMEOUT, 32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_FINISH, FIN_ERROR},
    '{ 1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_GARBAGE, 32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_EOF,     32'hFFFF_FFFF, SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CRCG,    11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CRCQ,    11'h7FF}, 1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CRCE,    11'd1024},1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CRCG,    11'd5},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'd7,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'd2048,      SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CRC_ERR, 11'd0},   1'b1, ACT_FINISH, FIN_ERROR},
    '{-1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_TIMEOUT, 11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_UNDEF,   11'd9},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CRCW,    11'd64},  1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_FILE,    32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_EOF,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_FINISH, FIN_EOF},
    '{-1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_SKIP,    32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_FINISH, FIN_SKIP},
    '{-1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_OTHER,   32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_FINISH, FIN_ERROR},
    '{-1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_HEADER, HK_DATA,    32'h0,         SE_CANCEL,  11'd0},   1'b0, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_SUBPKT, HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_FINISH, FIN_ERROR},
    '{-1,  1, '{REQ_START,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_HDR, FIN_EOF},
    '{-1,  1, '{REQ_ABORT,  HK_NAK,     32'h0,         SE_CANCEL,  11'd0},   1'b1, ACT_FINISH, FIN_ERROR}
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void add_out(action_e a, hdr_type_e h, logic [PosW-1:0] p,
                                  logic [CntW-1:0] w, fin_e f);
    batch.push_back('{a, h, p, w, f, 1'b0});
  endfunction

  function automatic void send_zrpos();
    add_out(ACT_HDR, HT_ZRPOS, file_pos, '0, FIN_EOF);
  endfunction

  function automatic void end_file(fin_e f);
    add_out(ACT_FINISH, HT_ZRPOS, '0, '0, f);
    rx_phase = RX_IDLE;
  endfunction

  function automatic bit take_retry();
    if (retries == '0) begin
      end_file(FIN_ERROR);
      return 1'b0;
    end
    retries = retries - 1'b1;
    return 1'b1;
  endfunction

  function automatic void commit_data(logic [CntW-1:0] cnt);
    logic [CntW-1:0] c;
    c = (cnt > MAX_SUBPKT) ? CntW'(MAX_SUBPKT) : cnt;
    retries = RetryW'(retry_lim);
    add_out(ACT_WRITE, HT_ZRPOS, '0, c, FIN_EOF);
    file_pos = file_pos + PosW'(c);
  endfunction

  function automatic void on_header(zm_req_t rq);
    case (rq.hk)
      HK_NAK, HK_TIMEOUT: if (take_retry()) send_zrpos();
      HK_FILE: rx_phase = RX_DISCARD;
      HK_EOF: if (rq.hpos == file_pos) end_file(FIN_EOF);
      HK_GARBAGE: begin
        if (take_retry()) begin
          add_out(ACT_ATTN, HT_ZRPOS, '0, '0, FIN_EOF);
          send_zrpos();
        end
      end
      HK_SKIP: end_file(FIN_SKIP);
      HK_DATA: begin
        if (rq.hpos == file_pos) begin
          rx_phase = RX_DATA;
        end else if (take_retry()) begin
          add_out(ACT_ATTN, HT_ZRPOS, '0, '0, FIN_EOF);
          send_zrpos();
        end
      end
      default: end_file(FIN_ERROR);
    endcase
  endfunction

  function automatic void on_subpacket(zm_req_t rq);
    case (rq.spend)
      SE_CANCEL: end_file(FIN_ERROR);
      SE_CRC_ERR: begin
        if (take_retry()) begin
          rx_phase = RX_WAIT;
          add_out(ACT_ATTN, HT_ZRPOS, '0, '0, FIN_EOF);
          send_zrpos();
        end
      end
      SE_TIMEOUT: begin
        if (take_retry()) begin
          rx_phase = RX_WAIT;
          send_zrpos();
        end
      end
      SE_CRCW: begin
        commit_data(rq.cnt);
        add_out(ACT_HDR, HT_ZACK, file_pos, '0, FIN_EOF);
        add_out(ACT_XON, HT_ZRPOS, '0, '0, FIN_EOF);
        rx_phase = RX_WAIT;
      end
      SE_CRCQ: begin
        commit_data(rq.cnt);
        add_out(ACT_HDR, HT_ZACK, file_pos, '0, FIN_EOF);
      end
      SE_CRCG: commit_data(rq.cnt);
      SE_CRCE: begin
        commit_data(rq.cnt);
        rx_phase = RX_WAIT;
      end
      default: begin
        rx_phase = RX_WAIT;
        send_zrpos();
      end
    endcase
  endfunction

  function automatic void advance_rx(zm_req_t rq);
    batch.delete();
    case (rq.kind)
      REQ_START: begin
        file_pos = '0;
        retries  = RetryW'(retry_lim);
        rx_phase = RX_WAIT;
        send_zrpos();
      end
      REQ_HEADER: if (rx_phase == RX_WAIT) on_header(rq);
      REQ_SUBPKT: begin
        if (rx_phase == RX_DATA) begin
          on_subpacket(rq);
        end else if (rx_phase == RX_DISCARD) begin
          rx_phase = RX_WAIT;
          send_zrpos();
        end
      end
      default: if (rx_phase != RX_IDLE) end_file(FIN_ERROR);
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
  endfunction

  // ----------------------------------------------------------------- stimulus

  // mostly well-formed traffic for the predicted phase, some pure noise
  function automatic zm_req_t pick_request();
    zm_req_t rq;
    int roll;
    rq.kind  = req_e'($urandom_range(0, 3));
    rq.hk    = hdr_kind_e'($urandom_range(0, 7));
    rq.hpos  = $urandom;
    rq.spend = 3'($urandom_range(0, 7));
    rq.cnt   = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                            : 11'($urandom_range(0, MAX_SUBPKT));
    if ($urandom_range(0, 99) < 8) return rq;
    roll = $urandom_range(0, 99);
    case (rx_phase)
      RX_IDLE: rq.kind = REQ_START;
      RX_WAIT: begin
        rq.kind = REQ_HEADER;
        if (roll < 55) begin
          rq.hk = HK_DATA;
          rq.hpos = file_pos;
        end else if (roll < 62) begin
          rq.hk = HK_FILE;
        end else if (roll < 67) begin
          rq.hk = HK_EOF;
          rq.hpos = file_pos;
        end else if (roll < 71) begin
          rq.hk = HK_EOF;
        end else if (roll < 76) begin
          rq.hk = HK_NAK;
        end else if (roll < 81) begin
          rq.hk = HK_TIMEOUT;
        end else if (roll < 86) begin
          rq.hk = HK_GARBAGE;
        end else if (roll < 91) begin
          rq.hk = HK_DATA;
        end else if (roll < 94) begin
          rq.hk = HK_SKIP;
        end else if (roll < 96) begin
          rq.hk = HK_OTHER;
        end else if (roll < 98) begin
          rq.kind = REQ_START;
        end else begin
          rq.kind = REQ_ABORT;
        end
      end
      default: begin
        rq.kind = REQ_SUBPKT;
        if (roll < 40)      rq.spend = SE_CRCG;
        else if (roll < 60) rq.spend = SE_CRCQ;
        else if (roll < 72) rq.spend = SE_CRCW;
        else if (roll < 80) rq.spend = SE_CRCE;
        else if (roll < 87) rq.spend = SE_CRC_ERR;
        else if (roll < 93) rq.spend = SE_TIMEOUT;
        else if (roll < 96) rq.spend = SE_CANCEL;
        else if (roll < 98) rq.spend = SE_UNDEF;
        else                rq.kind  = REQ_ABORT;
      end
    endcase
    return rq;
  endfunction

  // drive one request, wait for its handshake, then queue what it should cause
  task automatic apply_request(zm_req_t rq, bit typed, action_e act, fin_e fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.req_type        = rq.kind;
    req_if.header_kind     = rq.hk;
    req_if.header_position = rq.hpos;
    req_if.subpacket_end   = rq.spend;
    req_if.subpacket_count = rq.cnt;
    req_if.valid           = 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    requests_sent++;
    advance_rx(rq);
    if (typed) begin
      results_due.push_back('{act, HT_ZRPOS, '0, '0, fin, 1'b1});
    end else begin
      foreach (batch[k]) results_due.push_back(batch[k]);
    end
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_retry_limit(logic [7:0] v);
    quiesce();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    retry_lim  = v;
    settings_cnt++;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ------------------------------------------------------------- result side

  initial begin
    int stall;
    res_if.ready = 1'b0;
    while (rst_ni !== 1'b1) @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    rx_out_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, action %0d", res_if.action));
      end else begin
        want = results_due.pop_front();
        if (res_if.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", res_if.action, want.action));
        if (res_if.send_header_type !== want.htype)
          report_mismatch($sformatf("send_header_type %0d, want %0d",
                                    res_if.send_header_type, want.htype));
        if (res_if.send_position !== want.pos)
          report_mismatch($sformatf("send_position 0x%08h, want 0x%08h",
                                    res_if.send_position, want.pos));
        if (res_if.write_count !== want.wcnt)
          report_mismatch($sformatf("write_count %0d, want %0d", res_if.write_count, want.wcnt));
        if (res_if.finish_status !== want.fin)
          report_mismatch($sformatf("finish_status %0d, want %0d",
                                    res_if.finish_status, want.fin));
        if (res_if.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0d, want %0d", res_if.last_of_run, want.last));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             results_due.size());
    $display("zmodem_receive_data_controller test failed");
    $finish;
  end

  // -------------------------------------------------------------------- main

  initial begin
    int lim_plan [6] = '{0, 255, 3, -1, 20, 2};
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_data_i             = 8'd0;
    req_if.valid           = 1'b0;
    req_if.req_type        = '0;
    req_if.header_kind     = '0;
    req_if.header_position = '0;
    req_if.subpacket_end   = '0;
    req_if.subpacket_count = '0;
    calm                   = 1'b0;
    rx_phase               = RX_IDLE;
    file_pos               = '0;
    retries                = '0;
    retry_lim              = RetryLimitRst;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].set_limit >= 0) set_retry_limit(8'(dir_rows[i].set_limit));
      repeat (dir_rows[i].reps)
        apply_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].act, dir_rows[i].fin);
    end
    directed_sent = requests_sent;

    for (int p = 0; p < 6; p++) begin
      set_retry_limit((lim_plan[p] < 0) ? 8'($urandom_range(0, 255)) : 8'(lim_plan[p]));
      for (int k = 0; k < RAND_PER_SET; k++) begin
        calm = (k >= 20 && k < 32);
        apply_request(pick_request(), 1'b0, ACT_HDR, FIN_EOF);
      end
      calm = 1'b0;
    end

    quiesce();
    $display("ran %0d requests (%0d directed) over %0d retry_limit settings,",
             requests_sent, directed_sent, settings_cnt);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("zmodem_receive_data_controller test passed");
    end else begin
      $display("zmodem_receive_data_controller test failed");
    end
    $finish;
  end

endmodule
